/* hw/rtl/rwc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_pkg - shared definitions for the rolling weak checksum unit
// Default sizes, register map and the window length clamp.
// ----------------------------------------------------------------------------
package rwc_pkg;

   // default store depth and width of each running sum
   localparam int unsigned RWC_MAX_WINDOW = 2048;
   localparam int unsigned RWC_SUM_BITS   = 16;

   // register map
   localparam int unsigned RWC_CSR_ADDR_W  = 3;
   localparam int unsigned RWC_CSR_DATA_W  = 32;
   localparam int unsigned RWC_WIN_LEN_W   = 12;
   localparam logic [11:0] RWC_WIN_LEN_RST = 12'd512;

   // word index of each register
   typedef enum logic [0:0] {
      RWC_REG_WINDOW_LENGTH = 1'b0,
      RWC_REG_UNUSED        = 1'b1
   } rwc_reg_type;

   // window length as used by the datapath: zero means one, clamp at the store depth
   function automatic int unsigned rwc_clamp_len(input logic [11:0] wl,
                                                 input int unsigned max_w);
      int unsigned w;
      w = int'(wl);
      if (w == 0) begin
         w = 1;
      end
      if (w > max_w) begin
         w = max_w;
      end
      return w;
   endfunction

endpackage

/* hw/rtl/rolling_weak_checksum_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_weak_checksum_unit - sliding window weak checksum over a byte stream
// Keeps the last window_length bytes and rolls sums a and b one byte a time.
// ----------------------------------------------------------------------------
// The unit takes one byte per clock cycle and, once the window holds
// window_length bytes, returns one transaction per byte with the weak checksum
// (sum a in the low half, sum b above it) and the stream offset of the first
// byte in the window. A byte first enters the byte stage, which reads the
// byte leaving the window from the window store while the new byte is
// written; as it leaves that stage the sums take the rolling update and load the
// result register. The single read and single write of the window store per
// cycle set the rate of one byte per cycle; a stalled result holds back input
// only when the result register and the stage before it are both full.
// A restart flag on a byte begins a new stream at offset zero, and a write to
// window_length does the same for the next byte. Configure only while idle.
// ----------------------------------------------------------------------------
module rolling_weak_checksum_unit
   import rwc_pkg::*;
#(
   parameter int unsigned MAX_WINDOW = RWC_MAX_WINDOW,
   parameter int unsigned SUM_BITS   = RWC_SUM_BITS
) (
   input  logic                      clock,
   input  logic                      reset,

   // byte input channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_restart,

   // checksum result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [31:0]               rsp_checksum,
   output logic [31:0]               rsp_window_start,

   // register port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [RWC_CSR_ADDR_W-1:0] csr_paddr,
   input  logic [RWC_CSR_DATA_W-1:0] csr_pwdata,
   output logic [RWC_CSR_DATA_W-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned LW = $clog2(MAX_WINDOW + 1);

   // register state
   logic [RWC_WIN_LEN_W-1:0] win_len_ff;
   logic [LW-1:0]            eff_len_ff;

   // front end stream state
   logic [LW-1:0]            fill_count_ff;
   logic [AW-1:0]            wr_ptr_ff;

   // byte stage
   logic                     s1_valid_ff;
   logic [7:0]               s1_byte_ff;
   logic                     s1_restart_ff;
   logic                     s1_roll_ff;
   logic                     s1_emit_ff;
   logic [7:0]               old_byte_ff;

   // rolling sums
   logic [SUM_BITS-1:0]      sum_a_ff;
   logic [SUM_BITS-1:0]      sum_b_ff;
   logic [31:0]              start_off_ff;

   // result register
   logic                     rsp_valid_ff;
   logic [31:0]              rsp_checksum_ff;
   logic [31:0]              rsp_window_start_ff;

   // window store
   logic [7:0]               win_mem [MAX_WINDOW];

   logic                     csr_wr;
   logic                     req_fire;
   logic                     s1_fire;
   logic                     out_free;
   logic [LW-1:0]            base_fill;
   logic [AW-1:0]            base_ptr;
   logic                     roll;
   logic [LW-1:0]            fill_count_in;
   logic [AW-1:0]            wr_ptr_in;
   logic [AW:0]              ptr_ext;
   logic [AW:0]              len_ext;
   logic [AW-1:0]            old_idx;
   logic [SUM_BITS-1:0]      a_base;
   logic [SUM_BITS-1:0]      b_base;
   logic [31:0]              off_base;
   logic [LW+7:0]            drop_prod;
   logic [SUM_BITS-1:0]      sum_a_in;
   logic [SUM_BITS-1:0]      sum_b_in;
   logic [31:0]              start_off_in;

   // register access
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      case (rwc_reg_type'(csr_paddr[2]))
         RWC_REG_WINDOW_LENGTH: csr_prdata = RWC_CSR_DATA_W'(win_len_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // handshakes
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // front end: fill or roll decision, store addresses
   always_comb begin
      base_fill     = req_restart ? '0 : fill_count_ff;
      base_ptr      = req_restart ? '0 : wr_ptr_ff;
      roll          = (base_fill >= eff_len_ff);
      fill_count_in = roll ? base_fill : base_fill + LW'(1);
      wr_ptr_in     = (32'(base_ptr) == MAX_WINDOW - 1) ? '0 : base_ptr + AW'(1);
      ptr_ext       = {1'b0, base_ptr};
      len_ext       = (AW+1)'(eff_len_ff);
      if (ptr_ext >= len_ext) begin
         old_idx = AW'(ptr_ext - len_ext);
      end else begin
         old_idx = AW'(ptr_ext + (AW+1)'(MAX_WINDOW) - len_ext);
      end
   end

   // window store: read first, one write per byte
   always_ff @(posedge clock) begin
      if (req_fire) begin
         win_mem[base_ptr] <= req_data_byte;
         old_byte_ff       <= win_mem[old_idx];
      end
   end

   // configuration and front end state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff    <= RWC_WIN_LEN_RST;
         eff_len_ff    <= LW'(rwc_clamp_len(RWC_WIN_LEN_RST, MAX_WINDOW));
         fill_count_ff <= '0;
         wr_ptr_ff     <= '0;
      end else if (csr_wr && rwc_reg_type'(csr_paddr[2]) == RWC_REG_WINDOW_LENGTH) begin
         win_len_ff    <= csr_pwdata[RWC_WIN_LEN_W-1:0];
         eff_len_ff    <= LW'(rwc_clamp_len(csr_pwdata[RWC_WIN_LEN_W-1:0], MAX_WINDOW));
         fill_count_ff <= '0;
         wr_ptr_ff     <= '0;
      end else if (req_fire) begin
         fill_count_ff <= fill_count_in;
         wr_ptr_ff     <= wr_ptr_in;
      end
   end

   // byte stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff    <= req_data_byte;
         s1_restart_ff <= req_restart;
         s1_roll_ff    <= roll;
         s1_emit_ff    <= (fill_count_in == eff_len_ff);
      end
   end

   // rolling update of the sums
   always_comb begin
      a_base    = s1_restart_ff ? '0 : sum_a_ff;
      b_base    = s1_restart_ff ? '0 : sum_b_ff;
      off_base  = s1_restart_ff ? '0 : start_off_ff;
      drop_prod = (LW+8)'(eff_len_ff) * (LW+8)'(old_byte_ff);
      if (s1_roll_ff) begin
         sum_a_in     = a_base - SUM_BITS'(old_byte_ff) + SUM_BITS'(s1_byte_ff);
         sum_b_in     = b_base - SUM_BITS'(drop_prod) + sum_a_in;
         start_off_in = off_base + 32'd1;
      end else begin
         sum_a_in     = a_base + SUM_BITS'(s1_byte_ff);
         sum_b_in     = b_base + sum_a_in;
         start_off_in = off_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (csr_wr && rwc_reg_type'(csr_paddr[2]) == RWC_REG_WINDOW_LENGTH)) begin
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
         start_off_ff <= '0;
      end else if (s1_fire) begin
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         start_off_ff <= start_off_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_emit_ff) begin
         rsp_checksum_ff     <= 32'({sum_b_in, sum_a_in});
         rsp_window_start_ff <= start_off_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_checksum     = rsp_checksum_ff;
   assign rsp_window_start = rsp_window_start_ff;

   // checks
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= eff_len_ff)
      else $error("fill count above window length");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(wr_ptr_ff) < MAX_WINDOW)
      else $error("write pointer beyond store depth");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff)
      else $error("byte stage dropped a stalled byte");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire && s1_emit_ff))
      else $error("result without an emitting byte");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the rolling weak checksum unit
// Feeds byte streams under several window lengths, predicts every checksum
// transaction with a cycle-free software copy of the rolling sums and compares
// each result in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import rwc_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 1000000;
   localparam int unsigned SQUEEZE_CYCLES = 400;
   localparam int unsigned STORE_DEPTH    = 2048;
   localparam logic [RWC_CSR_ADDR_W-1:0] WIN_LEN_ADDR =
      RWC_CSR_ADDR_W'(4 * int'(RWC_REG_WINDOW_LENGTH));

   typedef struct {
      logic [7:0]  data;
      logic        restart;
      int unsigned gap;
   } byte_item_type;

   typedef struct {
      logic [31:0] checksum;
      logic [31:0] window_start;
   } checksum_type;

   // clock, reset and block inputs, known from time zero
   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic [7:0]                req_data_byte    = 8'h00;
   logic                      req_restart      = 1'b0;
   logic                      rsp_ready        = 1'b0;
   logic                      csr_psel         = 1'b0;
   logic                      csr_penable      = 1'b0;
   logic                      csr_pwrite       = 1'b0;
   logic [RWC_CSR_ADDR_W-1:0] csr_paddr        = '0;
   logic [RWC_CSR_DATA_W-1:0] csr_pwdata       = '0;

   logic                      req_ready;
   logic                      rsp_valid;
   logic [31:0]               rsp_checksum;
   logic [31:0]               rsp_window_start;
   logic [RWC_CSR_DATA_W-1:0] csr_prdata;
   logic                      csr_pready;

   // predicted window contents and running sums
   logic [7:0]  win_bytes [STORE_DEPTH];
   logic [15:0] sum_lo;
   logic [15:0] sum_hi;
   int unsigned fill_cnt;
   logic [31:0] first_offset;
   logic [10:0] wr_slot;
   logic [11:0] win_len_cfg = RWC_WIN_LEN_RST;

   byte_item_type byte_items [$];
   checksum_type  expected_sums [$];

   int          error_count     = 0;
   int unsigned cycle_count     = 0;
   int unsigned send_wait       = 0;
   int unsigned send_calm_left  = 0;
   int unsigned rsp_hold_left   = 0;
   int unsigned rsp_calm_left   = 0;
   logic        squeeze_req     = 1'b0;
   logic        squeeze_done    = 1'b0;

   rolling_weak_checksum_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_checksum     (rsp_checksum),
      .rsp_window_start (rsp_window_start),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #2 clock = ~clock;

   // restart or register write: empty window, sums and offset back to zero
   function automatic void clear_window_state();
      sum_lo       = '0;
      sum_hi       = '0;
      fill_cnt     = 0;
      first_offset = '0;
      wr_slot      = '0;
   endfunction

   // take one byte into the predicted window, queue the checksum it yields
   function automatic void roll_checksum(input logic [7:0] din, input logic rst);
      int unsigned  w;
      logic [10:0]  old_slot;
      logic [7:0]   oldest;
      checksum_type want;
      w = int'(win_len_cfg);
      if (w == 0) begin
         w = 1;
      end
      if (w > STORE_DEPTH) begin
         w = STORE_DEPTH;
      end
      if (rst) begin
         clear_window_state();
      end
      if (fill_cnt < w) begin
         win_bytes[wr_slot] = din;
         sum_lo = sum_lo + 16'(din);
         sum_hi = sum_hi + sum_lo;
         fill_cnt++;
      end else begin
         // oldest byte sits w slots behind the write slot, modulo the depth
         old_slot = 11'(int'(wr_slot) + STORE_DEPTH - w);
         oldest   = win_bytes[old_slot];
         win_bytes[wr_slot] = din;
         sum_lo = sum_lo - 16'(oldest) + 16'(din);
         sum_hi = sum_hi - 16'(w * 32'(oldest)) + sum_lo;
         first_offset = first_offset + 32'd1;
      end
      wr_slot = wr_slot + 11'd1;
      if (fill_cnt == w) begin
         want.checksum     = {sum_hi, sum_lo};
         want.window_start = first_offset;
         expected_sums.push_back(want);
      end
   endfunction

   // mostly uniform bytes, with the extremes weighted up
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // append a byte with its idle gap; occasional stretches without gaps
   function automatic void queue_byte(input logic [7:0] d, input logic r);
      byte_item_type item;
      item.data    = d;
      item.restart = r;
      if (send_calm_left > 0) begin
         send_calm_left--;
         item.gap = 0;
      end else begin
         if ($urandom_range(0, 39) == 0) begin
            send_calm_left = $urandom_range(10, 50);
         end
         item.gap = $urandom_range(0, 13);
      end
      byte_items.push_back(item);
   endfunction

   // stall before the next result; same stretch scheme as the sender
   function automatic int unsigned draw_rsp_stall();
      if (rsp_calm_left > 0) begin
         rsp_calm_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         rsp_calm_left = $urandom_range(10, 50);
      end
      return $urandom_range(0, 13);
   endfunction

   // block drained: no pending bytes, no open transaction, no result owed
   task automatic wait_idle();
      @(negedge clock);
      while (byte_items.size() != 0 || req_valid || expected_sums.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // apb write of window_length followed by a readback
   task automatic set_window_length(input logic [11:0] value);
      logic [RWC_CSR_DATA_W-1:0] rd;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WIN_LEN_ADDR;
      csr_pwdata  <= RWC_CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      win_len_cfg = value;
      clear_window_state();
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd[RWC_WIN_LEN_W-1:0] != value) begin
         $display("%0t: window_length readback mismatch, expected %h, actual %h",
                  $time, value, rd[RWC_WIN_LEN_W-1:0]);
         error_count++;
      end
   endtask

   // input side: one transaction per pending byte, gap after each
   always @(posedge clock) begin : req_side
      byte_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && req_ready) begin
            roll_checksum(req_data_byte, req_restart);
         end
         if (!req_valid || req_ready) begin
            if (send_wait != 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (byte_items.size() != 0) begin
               next_item = byte_items.pop_front();
               req_data_byte <= next_item.data;
               req_restart   <= next_item.restart;
               req_valid     <= 1'b1;
               send_wait     <= next_item.gap;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side: compare against the oldest prediction, then pace ready
   always @(posedge clock) begin : rsp_side
      checksum_type want;
      int unsigned  stall;
      if (reset) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               $display("%0t: unexpected result, checksum %h, window start %h",
                        $time, rsp_checksum, rsp_window_start);
               error_count++;
            end else begin
               want = expected_sums.pop_front();
               if (want.checksum != rsp_checksum) begin
                  $display("%0t: checksum mismatch, expected %h, actual %h",
                           $time, want.checksum, rsp_checksum);
                  error_count++;
               end
               if (want.window_start != rsp_window_start) begin
                  $display("%0t: window start mismatch, expected %h, actual %h",
                           $time, want.window_start, rsp_window_start);
                  error_count++;
               end
            end
         end
         if (squeeze_req && !squeeze_done) begin
            // long hold-off so the unit backs up into its input
            squeeze_done  <= 1'b1;
            rsp_hold_left <= SQUEEZE_CYCLES;
            rsp_ready     <= 1'b0;
         end else if (rsp_hold_left != 0) begin
            rsp_hold_left <= rsp_hold_left - 1;
            rsp_ready     <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            stall = draw_rsp_stall();
            if (stall != 0) begin
               rsp_ready     <= 1'b0;
               rsp_hold_left <= stall - 1;
            end else begin
               rsp_ready <= 1'b1;
            end
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // stimulus sequence
   initial begin : stimulus
      int unsigned w;
      int unsigned n;
      clear_window_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // window length left at its reset value: window never fills, no results
      @(negedge clock);
      repeat (300) queue_byte(pick_byte(), 1'b0);
      wait_idle();

      // zero length acts as one byte; extremes and restarts on some bytes
      set_window_length(12'd0);
      @(negedge clock);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'hFE, 1'b0);
      queue_byte(8'h80, 1'b1);
      queue_byte(8'h7F, 1'b0);
      wait_idle();

      // two byte window: restarts on a full window
      set_window_length(12'd2);
      @(negedge clock);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h01, 1'b0);
      wait_idle();

      // oversize length saturates to the store depth, window stays filling
      set_window_length(12'hFFF);
      @(negedge clock);
      repeat (16) queue_byte(pick_byte(), 1'b0);
      wait_idle();

      // one byte window, back-to-back input while the result side holds off
      set_window_length(12'd1);
      @(negedge clock);
      squeeze_req    = 1'b1;
      send_calm_left = 60;
      repeat (60) queue_byte(pick_byte(), 1'b0);
      wait_idle();

      // random short windows with rare restarts
      for (int p = 0; p < 4; p++) begin
         w = $urandom_range(1, 24);
         set_window_length(12'(w));
         @(negedge clock);
         n = w + 20;
         repeat (n) queue_byte(pick_byte(), $urandom_range(0, 29) == 0);
         wait_idle();
      end

      repeat (12) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
